@@ sv/fpa_pkg.sv @@
package fpa_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_DEFAULT  = 8;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } op_t;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              cmp;
        logic              dz;
        logic              is_mul;
        logic              is_div;
        logic              neg;
        logic [DATA_W-1:0] divisor;
    } side_t;

endpackage

@@ sv/fpa_front.sv @@
module fpa_front #(
    parameter int FRAC = fpa_pkg::FRAC_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              valid_in,
    input  logic [3:0]                        opcode,
    input  logic signed [fpa_pkg::DATA_W-1:0] a_raw,
    input  logic signed [fpa_pkg::DATA_W-1:0] b_raw,
    output logic                              valid_reg,
    output fpa_pkg::side_t                    side_reg,
    output logic signed [2*fpa_pkg::DATA_W-1:0] prod_reg,
    output logic [fpa_pkg::DATA_W-1:0]        abs_a_reg
);
    import fpa_pkg::*;

    side_t                   side_next;
    logic signed [2*DATA_W-1:0] prod_next;
    logic [DATA_W-1:0]       abs_a_next;
    logic                    lt, gt, eq;

    always_comb begin
        lt         = a_raw < b_raw;
        gt         = a_raw > b_raw;
        eq         = a_raw == b_raw;
        prod_next  = a_raw * b_raw;
        abs_a_next = a_raw[DATA_W-1] ? DATA_W'(-a_raw) : DATA_W'(a_raw);
        side_next         = '0;
        side_next.divisor = b_raw[DATA_W-1] ? DATA_W'(-b_raw) : DATA_W'(b_raw);
        side_next.neg     = a_raw[DATA_W-1] ^ b_raw[DATA_W-1];
        case (op_t'(opcode))
            OP_ADD:     side_next.res = DATA_W'(a_raw + b_raw);
            OP_SUB:     side_next.res = DATA_W'(a_raw - b_raw);
            OP_MUL:     side_next.is_mul = 1'b1;
            OP_DIV: begin
                if (b_raw == '0) begin
                    side_next.dz = 1'b1;
                end else begin
                    side_next.is_div = 1'b1;
                end
            end
            OP_GT:      side_next.cmp = gt;
            OP_LT:      side_next.cmp = lt;
            OP_GE:      side_next.cmp = !lt;
            OP_LE:      side_next.cmp = !gt;
            OP_EQ:      side_next.cmp = eq;
            OP_NE:      side_next.cmp = !eq;
            OP_MIN:     side_next.res = lt ? a_raw : b_raw;
            OP_MAX:     side_next.res = gt ? a_raw : b_raw;
            OP_INC:     side_next.res = DATA_W'(a_raw + 1);
            OP_DEC:     side_next.res = DATA_W'(a_raw - 1);
            OP_TOINT:   side_next.res = DATA_W'(a_raw >>> FRAC);
            OP_FROMINT: side_next.res = DATA_W'(a_raw << FRAC);
            default:    side_next.res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg  <= side_next;
            prod_reg  <= prod_next;
            abs_a_reg <= abs_a_next;
        end
    end

endmodule

@@ sv/fpa_div_step.sv @@
module fpa_div_step #(
    parameter int DVD_W = fpa_pkg::DATA_W + fpa_pkg::FRAC_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          valid_in,
    input  fpa_pkg::side_t                side_in,
    input  logic [fpa_pkg::DATA_W-1:0]    rem_in,
    input  logic [DVD_W-1:0]              dvd_in,
    output logic                          valid_reg,
    output fpa_pkg::side_t                side_reg,
    output logic [fpa_pkg::DATA_W-1:0]    rem_reg,
    output logic [DVD_W-1:0]              dvd_reg
);
    import fpa_pkg::*;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              qbit;
    logic [DATA_W-1:0] rem_next;
    logic [DVD_W-1:0]  dvd_next;

    always_comb begin
        trial    = {rem_in, dvd_in[DVD_W-1]};
        diff     = trial - {1'b0, side_in.divisor};
        qbit     = !diff[DATA_W];
        rem_next = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        dvd_next = {dvd_in[DVD_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_in;
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
        end
    end

endmodule

@@ sv/fixed_point_alu.sv @@
// Channel  | Handshake          | Payload
// input    | s_valid / s_ready  | s_opcode, s_a_raw, s_b_raw
// result   | m_valid / m_ready  | m_result_raw, m_compare_true, m_divide_by_zero
//
// One transaction per cycle unless the result stalls. Input register, restoring
// divider chain of 32 + FRACTION_BITS one-bit stages, output register.
// Synchronous active-low reset clears all valid bits.
// A stalled result freezes the whole pipeline; s_ready drops until it moves.
module fixed_point_alu #(
    parameter int FRACTION_BITS = fpa_pkg::FRAC_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [3:0]                        s_opcode,
    input  logic signed [fpa_pkg::DATA_W-1:0] s_a_raw,
    input  logic signed [fpa_pkg::DATA_W-1:0] s_b_raw,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [fpa_pkg::DATA_W-1:0] m_result_raw,
    output logic                              m_compare_true,
    output logic                              m_divide_by_zero
);
    import fpa_pkg::*;

    localparam int DVD_W = DATA_W + FRACTION_BITS;

    logic                    en;
    logic                    f_valid;
    side_t                   f_side;
    logic signed [2*DATA_W-1:0] f_prod;
    logic [DATA_W-1:0]       f_abs_a;
    side_t                   side_head;

    logic                    valid_s [0:DVD_W];
    side_t                   side_s  [0:DVD_W];
    logic [DATA_W-1:0]       rem_s   [0:DVD_W];
    logic [DVD_W-1:0]        dvd_s   [0:DVD_W];

    logic                    m_valid_reg;
    logic [DATA_W-1:0]       m_result_reg;
    logic                    m_cmp_reg;
    logic                    m_dz_reg;
    logic [DATA_W-1:0]       quo;
    logic [DATA_W-1:0]       result_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    fpa_front #(.FRAC(FRACTION_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s_valid),
        .opcode    (s_opcode),
        .a_raw     (s_a_raw),
        .b_raw     (s_b_raw),
        .valid_reg (f_valid),
        .side_reg  (f_side),
        .prod_reg  (f_prod),
        .abs_a_reg (f_abs_a)
    );

    always_comb begin
        side_head = f_side;
        if (f_side.is_mul) begin
            side_head.res = f_prod[FRACTION_BITS+DATA_W-1:FRACTION_BITS];
        end
    end

    assign valid_s[0] = f_valid;
    assign side_s[0]  = side_head;
    assign rem_s[0]   = '0;
    assign dvd_s[0]   = {f_abs_a, {FRACTION_BITS{1'b0}}};

    for (genvar i = 0; i < DVD_W; i++) begin : g_div
        fpa_div_step #(.DVD_W(DVD_W)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (valid_s[i]),
            .side_in   (side_s[i]),
            .rem_in    (rem_s[i]),
            .dvd_in    (dvd_s[i]),
            .valid_reg (valid_s[i+1]),
            .side_reg  (side_s[i+1]),
            .rem_reg   (rem_s[i+1]),
            .dvd_reg   (dvd_s[i+1])
        );
    end

    always_comb begin
        quo = dvd_s[DVD_W][DATA_W-1:0];
        if (side_s[DVD_W].is_div) begin
            result_next = side_s[DVD_W].neg ? -quo : quo;
        end else begin
            result_next = side_s[DVD_W].res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= valid_s[DVD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_result_reg <= result_next;
            m_cmp_reg    <= side_s[DVD_W].cmp;
            m_dz_reg     <= side_s[DVD_W].dz;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_raw     = m_result_reg;
    assign m_compare_true   = m_cmp_reg;
    assign m_divide_by_zero = m_dz_reg;

endmodule

@@ sv/fpa_checker.sv @@
module fpa_assertions (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [fpa_pkg::DATA_W-1:0] m_result_raw,
    input logic                              m_compare_true,
    input logic                              m_divide_by_zero
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_raw))
        else $error("stalled result changed");

    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compare_true |-> m_result_raw == '0 && !m_divide_by_zero)
        else $error("compare result not zero");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_result_raw == '0)
        else $error("divide by zero result not zero");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");

endmodule

bind fixed_point_alu fpa_assertions u_fpa_assertions (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_raw     (m_result_raw),
    .m_compare_true   (m_compare_true),
    .m_divide_by_zero (m_divide_by_zero)
);

@@ verif/fpa_checker.sv @@
module fpa_checker #(
    parameter int FRACTION_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [3:0]  s_opcode,
    input  logic [31:0] s_a_raw,
    input  logic [31:0] s_b_raw,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_result_raw,
    input  logic        m_compare_true,
    input  logic        m_divide_by_zero,
    output int          error_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    typedef struct packed {
        logic [31:0] res;
        logic        cmp;
        logic        dz;
    } alu_out_t;

    alu_out_t expected_q[$];

    function automatic alu_out_t alu_compute(op_t op, logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_out_t r;
        logic signed [63:0] wide;
        r = '0;
        case (op)
            OP_ADD: r.res = a + b;
            OP_SUB: r.res = a - b;
            OP_MUL: begin
                wide = 64'(a) * 64'(b);
                r.res = 32'(wide >>> FRACTION_BITS);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    wide = 64'(a) <<< FRACTION_BITS;
                    r.res = 32'(wide / 64'(b));
                end
            end
            OP_GT: r.cmp = a > b;
            OP_LT: r.cmp = a < b;
            OP_GE: r.cmp = a >= b;
            OP_LE: r.cmp = a <= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_MIN: r.res = (a < b) ? a : b;
            OP_MAX: r.res = (a > b) ? a : b;
            OP_INC: r.res = a + 1;
            OP_DEC: r.res = a - 1;
            OP_TOINT: r.res = a >>> FRACTION_BITS;
            default: r.res = a << FRACTION_BITS;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    initial begin
        error_count = 0;
        pending_count = 0;
    end

    always @(posedge aclk) begin
        alu_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_q.push_back(alu_compute(op_t'(s_opcode), s_a_raw, s_b_raw));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction", m_result_raw, 32'h0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_result_raw !== want.res)
                        report_mismatch("result_raw", m_result_raw, want.res);
                    if (m_compare_true !== want.cmp)
                        report_mismatch("compare_true", 32'(m_compare_true), 32'(want.cmp));
                    if (m_divide_by_zero !== want.dz)
                        report_mismatch("divide_by_zero", 32'(m_divide_by_zero),
                                        32'(want.dz));
                end
            end
            pending_count <= expected_q.size();
        end
    end
endmodule

@@ verif/tb_fixed_point_alu.sv @@
module tb_fixed_point_alu;
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    localparam int LATENCY   = FRAC_DEFAULT + 34;
    localparam int N_RANDOM  = 1730;
    localparam int WD_LIMIT  = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_opcode = '0;
    logic signed [31:0] s_a_raw = '0;
    logic signed [31:0] s_b_raw = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_result_raw;
    logic        m_compare_true;
    logic        m_divide_by_zero;
    int          error_count;
    int          pending_count;
    int          sent_count = 0;
    int          idle_cycles = 0;
    bit          quiet_phase = 1'b0;
    bit          long_hold = 1'b0;

    always #1 aclk = ~aclk;

    fixed_point_alu i_dut (.*);

    fpa_checker u_checker (.*);

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(0);
            3: return 32'($urandom_range(0, 511)) - 32'd256;
            4: return 32'($urandom_range(0, 1)) << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_op(op_t op, logic [31:0] a, logic [31:0] b);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_a_raw  <= a;
        s_b_raw  <= b;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // receiver: random stalls, one long hold-off, none at the end
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                long_hold = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 4);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [31:0] edge_vals [6];
        int k;
        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                      32'h0000_0100, 32'hffff_ff00};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int op = 0; op < 16; op++)
            send_op(op_t'(op), edge_vals[op % 6], edge_vals[(op + 1) % 6]);
        send_op(OP_DIV, 32'h1234_5678, 32'h0);
        send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_MIN, 32'h0000_0500, 32'h0000_0500);
        send_op(OP_MAX, 32'hffff_fb00, 32'hffff_fb00);
        send_op(OP_TOINT, 32'hffff_ff01, 32'h0);
        send_op(OP_FROMINT, 32'h00ff_ffff, 32'h0);

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == 400)
                long_hold = 1'b1;
            if (k == 900) begin
                s_valid <= 1'b0;
                @(posedge aclk iff pending_count == 0);
            end
            if (k == N_RANDOM - 200)
                quiet_phase = 1'b1;
            send_op(op_t'($urandom_range(0, 15)), pick_operand(),
                    ($urandom_range(0, 9) == 0) ? 32'h0 : pick_operand());
        end
        s_valid <= 1'b0;

        @(posedge aclk iff pending_count == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Sent %0d transactions over all 16 opcodes, operand extremes,",
                 sent_count);
        $display("divide by zero, random stalls and a long result back-pressure.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
